// File: sv/secure_page_crc16_engine_assert.svh
// ----------------------------------------------------------------------------
// secure page crc16 engine assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef SECURE_PAGE_CRC16_ENGINE_ASSERT_SVH
`define SECURE_PAGE_CRC16_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked property, disabled while reset is active
`define SPCRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also evaluated during reset
`define SPCRC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SPCRC_ASSERT(lbl, prop, msg)

`define SPCRC_ASSERT_NR(lbl, prop, msg)

`endif

`endif

// File: sv/spcrc_pkg.sv
// ----------------------------------------------------------------------------
// spcrc package
// command and status codes, crc constants and the byte-wide crc update
// ----------------------------------------------------------------------------
package spcrc_pkg;

  localparam int unsigned PAGE_BYTES   = 64;
  localparam int unsigned MEMORY_BYTES = 131072;
  localparam int unsigned ADDR_W       = 17;

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] SEED_BIT16_ZERO = 16'hEFDF;
  localparam logic [15:0] SEED_BIT16_ONE  = 16'hFFFE;

  localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [ADDR_W:0]   PAGE_LIMIT = (ADDR_W + 1)'(MEMORY_BYTES - PAGE_BYTES);

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdData  = 2'd1,
    CmdCheck = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StMisaligned = 2'd1,
    StBeyond     = 2'd2,
    StMismatch   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] page_address;
    logic [7:0]        data_byte;
    logic [15:0]       received_crc;
    logic [15:0]       addr_hi_crc;
  } stage_t;

  // msb-first crc over one byte
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] r;
    r = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: sv/spcrc_req_if.sv
// ----------------------------------------------------------------------------
// spcrc request channel
// valid/ready channel carrying one command request
// ----------------------------------------------------------------------------
interface spcrc_req_if;

  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [16:0] page_address;
  logic [7:0]  data_byte;
  logic [15:0] received_crc;

  modport source (output valid, output command, output page_address,
                  output data_byte, output received_crc, input ready);
  modport sink (input valid, input command, input page_address,
                input data_byte, input received_crc, output ready);

endinterface

// File: sv/spcrc_rsp_if.sv
// ----------------------------------------------------------------------------
// spcrc response channel
// valid/ready channel carrying status and running crc
// ----------------------------------------------------------------------------
interface spcrc_rsp_if;

  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] crc_value;

  modport source (output valid, output status, output crc_value, input ready);
  modport sink (input valid, input status, input crc_value, output ready);

endinterface

// File: sv/secure_page_crc16_engine.sv
// ----------------------------------------------------------------------------
// secure page crc16 engine
// crc-16/ibm-3740 generation and check for secure page transfers
//
// channel  dir  payload                                          handshake
// req_i    in   command, page_address, data_byte, received_crc   valid/ready
// rsp_o    out  status, crc_value                                valid/ready
//
// one request per cycle unless rsp_o stalls; passes request then result register
// the byte-wide crc update between the request register and the result register
// sets the cycle; the address high byte is folded ahead of the request register
// reset sets the running crc to 0xffff and empties both stages
// a stalled result holds while a request waits in the request register
// ----------------------------------------------------------------------------
module secure_page_crc16_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  spcrc_req_if.sink   req_i,
  spcrc_rsp_if.source rsp_o
);
  import spcrc_pkg::*;

  logic   stage_valid;
  logic   stage_ready;
  stage_t stage;

  spcrc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .stage_ready_i (stage_ready)
  );

  spcrc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .rsp_o         (rsp_o)
  );

endmodule

// File: sv/spcrc_in_stage.sv
// ----------------------------------------------------------------------------
// spcrc input stage
// registers the request and pre-folds the seed over address bits 15..8
// ----------------------------------------------------------------------------
module spcrc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  spcrc_req_if.sink           req_i,
  output logic                stage_valid_o,
  output spcrc_pkg::stage_t   stage_o,
  input  logic                stage_ready_i
);
  import spcrc_pkg::*;

  logic        valid_q;
  stage_t      stage_q;
  stage_t      stage_d;
  logic [15:0] seed;
  logic        load;

  assign req_i.ready = !valid_q || stage_ready_i;
  assign load        = req_i.valid && req_i.ready;

  // seed depends only on address bit 16
  always_comb begin
    seed                 = req_i.page_address[16] ? SEED_BIT16_ONE : SEED_BIT16_ZERO;
    stage_d.command      = req_i.command;
    stage_d.page_address = req_i.page_address;
    stage_d.data_byte    = req_i.data_byte;
    stage_d.received_crc = req_i.received_crc;
    stage_d.addr_hi_crc  = crc_fold_byte(seed, req_i.page_address[15:8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

// File: sv/spcrc_core.sv
// ----------------------------------------------------------------------------
// spcrc core
// address checks, crc update, running crc state and result register
// ----------------------------------------------------------------------------
`include "secure_page_crc16_engine_assert.svh"

module spcrc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stage_valid_i,
  input  spcrc_pkg::stage_t   stage_i,
  output logic                stage_ready_o,
  spcrc_rsp_if.source         rsp_o
);
  import spcrc_pkg::*;

  logic        rsp_valid_q;
  status_e     status_q;
  status_e     status_d;
  logic [15:0] rsp_crc_q;
  logic [15:0] crc_q;
  logic [15:0] crc_d;
  logic        fire;

  assign stage_ready_o = !rsp_valid_q || rsp_o.ready;
  assign fire          = stage_valid_i && stage_ready_o;

  always_comb begin
    status_d = StOk;
    crc_d    = crc_q;
    case (stage_i.command)
      CmdStart: begin
        if ((stage_i.page_address & PAGE_MASK) != '0) begin
          status_d = StMisaligned;
        end else if ({1'b0, stage_i.page_address} > PAGE_LIMIT) begin
          status_d = StBeyond;
        end else begin
          crc_d = crc_fold_byte(stage_i.addr_hi_crc, stage_i.page_address[7:0]);
        end
      end
      CmdData: begin
        crc_d = crc_fold_byte(crc_q, stage_i.data_byte);
      end
      CmdCheck: begin
        status_d = (stage_i.received_crc == crc_q) ? StOk : StMismatch;
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      crc_q       <= CRC_INIT;
    end else begin
      if (stage_ready_o) begin
        rsp_valid_q <= stage_valid_i;
      end
      if (fire) begin
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      rsp_crc_q <= crc_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.crc_value = rsp_crc_q;

  `SPCRC_ASSERT(a_crc_idle_hold, !fire |=> crc_q == $past(crc_q), "crc changed without request")
  `SPCRC_ASSERT(a_err_keeps_crc, fire && status_d != StOk |=> crc_q == $past(crc_q),
                "failed request changed crc")
  `SPCRC_ASSERT(a_check_reports_crc, fire && stage_i.command == CmdCheck |=> rsp_crc_q == crc_q,
                "check result crc differs from running crc")
  `SPCRC_ASSERT(a_result_tracks_state, rsp_valid_q && $past(fire) |-> rsp_crc_q == crc_q,
                "result crc not equal to running crc")

endmodule
